// ===== hdl/csma_pkg.sv =====
// ============================================================================
// CSMA-CA backoff controller package
// Event, result and phase codes, register indexes and fixed limits.
// ============================================================================
package csma_pkg;

    localparam logic [3:0] MAX_EXPONENT_LIMIT = 4'd8;
    localparam logic [1:0] CW_INIT            = 2'd2;
    localparam logic [3:0] BLE_EXPONENT_CAP   = 4'd2;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_CCA    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_CCA  = 2'd1,
        EV_IDLE = 2'd2,
        EV_FAIL = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BACKOFF = 2'd1,
        PH_CCA     = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_SLOTTED_MODE     = 3'd0,
        REG_BATTERY_LIFE_EXT = 3'd1,
        REG_MIN_EXPONENT     = 3'd2,
        REG_MAX_EXPONENT     = 3'd3,
        REG_MAX_BACKOFFS     = 3'd4,
        REG_UNIT_PERIOD      = 3'd5
    } reg_index_t;

endpackage

// ===== hdl/csma_ca_backoff_controller_top.sv =====
// ============================================================================
// CSMA-CA backoff controller
// Slotted or unslotted 802.15.4-style channel access: random backoff in
// symbol ticks, CCA requests, contention window and backoff limit.
// ============================================================================
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[7:0]
//  in       in         in_valid/in_ready    kind, cca_idle, random_draw
//  out      out        out_valid/out_ready  event_res, backoff_number, active
//
//  One event per cycle while in_ready is high; its result is registered and appears the next cycle.
//  Controller state updates at the accepting edge.
//  A result waiting on out_ready holds in_ready low unless taken that cycle.
//  cfg_ready is always high; a register write takes effect at its next use.
//  rst_n resets controller state and out_valid and loads the register defaults; result registers are not reset.
// ============================================================================
module csma_ca_backoff_controller_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic       cca_idle,
    input  logic [7:0] random_draw,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_res,
    output logic [2:0] backoff_number,
    output logic       active
);

    logic       slotted_mode_reg;
    logic       battery_life_ext_reg;
    logic [3:0] min_exponent_reg;
    logic [3:0] max_exponent_reg;
    logic [2:0] max_backoffs_reg;
    logic [7:0] unit_period_reg;

    csma_pkg::phase_t phase_reg, phase_next;
    logic [3:0] exponent_reg, exponent_next;
    logic [2:0] busy_count_reg, busy_count_next;
    logic [1:0] cw_reg, cw_next;
    logic [7:0] periods_left_reg, periods_left_next;
    logic [7:0] symbols_left_reg, symbols_left_next;

    logic             out_valid_reg;
    csma_pkg::event_t event_res_reg, event_next;
    logic [2:0]       backoff_number_reg;
    logic             active_reg;

    logic             in_accept;
    csma_pkg::kind_t  kind_in;

    logic [3:0] start_exp;
    logic [3:0] min_capped;
    logic [3:0] top_exp;
    logic [4:0] exp_inc;
    logic [3:0] busy_exp;
    logic [3:0] n_busy;
    logic       busy_fail;
    logic [3:0] bo_exp;
    logic [8:0] bo_mask;
    logic [7:0] bo_periods;
    logic       bo_zero;
    logic [7:0] sym_dec;
    logic [7:0] per_dec;
    logic [7:0] unit_syms;

    function automatic logic [3:0] cap_exp(input logic [3:0] e);
        cap_exp = (e > csma_pkg::MAX_EXPONENT_LIMIT) ? csma_pkg::MAX_EXPONENT_LIMIT : e;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign kind_in   = csma_pkg::kind_t'(kind);

    assign unit_syms  = (unit_period_reg == 8'd0) ? 8'd1 : unit_period_reg;
    assign min_capped = cap_exp(min_exponent_reg);
    assign start_exp  = (slotted_mode_reg && battery_life_ext_reg
                         && min_capped > csma_pkg::BLE_EXPONENT_CAP)
                        ? csma_pkg::BLE_EXPONENT_CAP : min_capped;
    assign top_exp    = cap_exp(max_exponent_reg);
    assign exp_inc    = {1'b0, exponent_reg} + 5'd1;
    assign busy_exp   = (exp_inc < {1'b0, top_exp}) ? exp_inc[3:0] : top_exp;
    assign n_busy     = {1'b0, busy_count_reg} + 4'd1;
    assign busy_fail  = n_busy > {1'b0, max_backoffs_reg};

    assign bo_exp     = (kind_in == csma_pkg::KIND_START) ? start_exp : cap_exp(busy_exp);
    assign bo_mask    = (9'd1 << bo_exp) - 9'd1;
    assign bo_periods = random_draw & bo_mask[7:0];
    assign bo_zero    = (bo_periods == 8'd0);

    assign sym_dec = (symbols_left_reg != 8'd0) ? symbols_left_reg - 8'd1 : symbols_left_reg;
    assign per_dec = (periods_left_reg != 8'd0) ? periods_left_reg - 8'd1 : periods_left_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        exponent_next     = exponent_reg;
        busy_count_next   = busy_count_reg;
        cw_next           = cw_reg;
        periods_left_next = periods_left_reg;
        symbols_left_next = symbols_left_reg;
        case (kind_in)
            csma_pkg::KIND_START:
            begin
                busy_count_next   = 3'd0;
                cw_next           = csma_pkg::CW_INIT;
                exponent_next     = start_exp;
                periods_left_next = bo_periods;
                if (bo_zero)
                begin
                    phase_next = csma_pkg::PH_CCA;
                end
                else
                begin
                    symbols_left_next = unit_syms;
                    phase_next        = csma_pkg::PH_BACKOFF;
                end
            end
            csma_pkg::KIND_CANCEL:
            begin
                phase_next = csma_pkg::PH_IDLE;
            end
            csma_pkg::KIND_TICK:
            begin
                if (phase_reg == csma_pkg::PH_BACKOFF)
                begin
                    symbols_left_next = sym_dec;
                    if (sym_dec == 8'd0)
                    begin
                        periods_left_next = per_dec;
                        if (per_dec == 8'd0)
                        begin
                            phase_next = csma_pkg::PH_CCA;
                        end
                        else
                        begin
                            symbols_left_next = unit_syms;
                        end
                    end
                end
            end
            csma_pkg::KIND_CCA:
            begin
                if (phase_reg == csma_pkg::PH_CCA)
                begin
                    if (cca_idle)
                    begin
                        if (slotted_mode_reg)
                        begin
                            if (cw_reg <= 2'd1)
                            begin
                                cw_next    = 2'd0;
                                phase_next = csma_pkg::PH_IDLE;
                            end
                            else
                            begin
                                cw_next = cw_reg - 2'd1;
                            end
                        end
                        else
                        begin
                            phase_next = csma_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        if (slotted_mode_reg)
                        begin
                            cw_next = csma_pkg::CW_INIT;
                        end
                        exponent_next   = busy_exp;
                        busy_count_next = n_busy[3] ? 3'd7 : n_busy[2:0];
                        if (busy_fail)
                        begin
                            phase_next = csma_pkg::PH_IDLE;
                        end
                        else
                        begin
                            periods_left_next = bo_periods;
                            if (bo_zero)
                            begin
                                phase_next = csma_pkg::PH_CCA;
                            end
                            else
                            begin
                                symbols_left_next = unit_syms;
                                phase_next        = csma_pkg::PH_BACKOFF;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        event_next = csma_pkg::EV_NONE;
        case (kind_in)
            csma_pkg::KIND_START:
            begin
                if (bo_zero)
                begin
                    event_next = csma_pkg::EV_CCA;
                end
            end
            csma_pkg::KIND_TICK:
            begin
                if (phase_reg == csma_pkg::PH_BACKOFF && sym_dec == 8'd0 && per_dec == 8'd0)
                begin
                    event_next = csma_pkg::EV_CCA;
                end
            end
            csma_pkg::KIND_CCA:
            begin
                if (phase_reg == csma_pkg::PH_CCA)
                begin
                    if (cca_idle)
                    begin
                        if (slotted_mode_reg && cw_reg > 2'd1)
                        begin
                            event_next = csma_pkg::EV_CCA;
                        end
                        else
                        begin
                            event_next = csma_pkg::EV_IDLE;
                        end
                    end
                    else if (busy_fail)
                    begin
                        event_next = csma_pkg::EV_FAIL;
                    end
                    else if (bo_zero)
                    begin
                        event_next = csma_pkg::EV_CCA;
                    end
                end
            end
            default:
            begin
                event_next = csma_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slotted_mode_reg     <= 1'b0;
            battery_life_ext_reg <= 1'b0;
            min_exponent_reg     <= 4'd3;
            max_exponent_reg     <= 4'd5;
            max_backoffs_reg     <= 3'd4;
            unit_period_reg      <= 8'd20;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (csma_pkg::reg_index_t'(cfg_index))
                csma_pkg::REG_SLOTTED_MODE:     slotted_mode_reg     <= cfg_data[0];
                csma_pkg::REG_BATTERY_LIFE_EXT: battery_life_ext_reg <= cfg_data[0];
                csma_pkg::REG_MIN_EXPONENT:     min_exponent_reg     <= cfg_data[3:0];
                csma_pkg::REG_MAX_EXPONENT:     max_exponent_reg     <= cfg_data[3:0];
                csma_pkg::REG_MAX_BACKOFFS:     max_backoffs_reg     <= cfg_data[2:0];
                csma_pkg::REG_UNIT_PERIOD:      unit_period_reg      <= cfg_data;
                default:                        unit_period_reg      <= unit_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= csma_pkg::PH_IDLE;
            exponent_reg     <= 4'd3;
            busy_count_reg   <= 3'd0;
            cw_reg           <= csma_pkg::CW_INIT;
            periods_left_reg <= 8'd0;
            symbols_left_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            exponent_reg     <= exponent_next;
            busy_count_reg   <= busy_count_next;
            cw_reg           <= cw_next;
            periods_left_reg <= periods_left_next;
            symbols_left_reg <= symbols_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            event_res_reg      <= event_next;
            backoff_number_reg <= busy_count_next;
            active_reg         <= (phase_next != csma_pkg::PH_IDLE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_res_reg;
    assign backoff_number = backoff_number_reg;
    assign active         = active_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted event produced no result");

    a_active_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> active_reg == (phase_reg != csma_pkg::PH_IDLE))
        else $error("active disagrees with phase");

    a_cancel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && kind_in == csma_pkg::KIND_CANCEL
        |=> event_res_reg == csma_pkg::EV_NONE && !active_reg)
        else $error("cancel left controller active");

    a_backoff_periods: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == csma_pkg::PH_BACKOFF |-> periods_left_reg != 8'd0)
        else $error("backoff with no periods left");

    a_exponent_capped: assert property (@(posedge clk) disable iff (!rst_n)
        exponent_reg <= csma_pkg::MAX_EXPONENT_LIMIT)
        else $error("exponent above limit");

endmodule
